// ===== design/tlg_pkg.sv =====
// ----------------------------------------------------------------------------
// tlg_pkg
// shared codes, defaults and controller/datapath interface types for the
// toroidal life grid engine
// ----------------------------------------------------------------------------
package tlg_pkg;

  localparam int DEF_ROWS = 64;
  localparam int DEF_COLS = 64;

  localparam int FUNC_W = 3;
  localparam int ROW_W  = 6;
  localparam int COL_W  = 6;

  localparam logic [FUNC_W-1:0] FUNC_WRITE  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_TOGGLE = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_STEP   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd4;

  typedef struct packed {
    logic capture;
    logic rd_cell;
    logic rd_step;
    logic wr_zero;
    logic wr_cell;
    logic wr_life;
    logic shift;
    logic flip;
    logic cnt_clr;
    logic cnt_inc;
    logic load_res;
  } tlg_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              in_grid;
    logic              running;
    logic              clear_last;
    logic              step_last;
    logic              step_ge1;
    logic              step_ge3;
    logic              out_busy;
  } tlg_status_t;

endpackage

// ===== design/tlg_datapath.sv =====
// ----------------------------------------------------------------------------
// tlg_datapath
// row-wide grid memory with two banks, row window and life rule for one
// whole row, item and result registers
// ----------------------------------------------------------------------------
module tlg_datapath import tlg_pkg::*; #(
  parameter int ROWS = DEF_ROWS,
  parameter int COLS = DEF_COLS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tlg_cmd_t          cmd_i,
  output tlg_status_t       status_o,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [ROW_W-1:0]  row_i,
  input  logic [COL_W-1:0]  column_i,
  input  logic              value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              cell_bit_o,
  output logic              took_effect_o
);

  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW   = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int CNTW = $clog2(ROWS + 3);

  logic [COLS-1:0] mem_q [2][ROWS];
  logic [COLS-1:0] rd_data_q;
  logic [COLS-1:0] win0_q, win1_q;
  logic [COLS-1:0] life_row, rmw_row, wr_data;
  logic            sel_q;
  logic            running_q;
  logic [CNTW-1:0] cnt_q, cnt_m1, cnt_m3;
  logic [FUNC_W-1:0] func_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  column_q;
  logic            value_q;
  logic            out_valid_q;
  logic            cell_bit_q, took_effect_q;
  logic            in_grid;
  logic [RW-1:0]   row_idx, rd_row, wr_row, step_rd_row;
  logic [CW-1:0]   col_idx;
  logic            wr_en, wr_bank;
  logic            res_cell, res_took;

  assign row_idx = RW'(row_q);
  assign col_idx = CW'(column_q);
  assign in_grid = (32'(row_q) < 32'(ROWS)) && (32'(column_q) < 32'(COLS));
  assign cnt_m1  = cnt_q - CNTW'(1);
  assign cnt_m3  = cnt_q - CNTW'(3);

  // wrap: first read is the last row, final read is row zero again
  always_comb begin
    if (cnt_q == '0) begin
      step_rd_row = RW'(ROWS - 1);
    end else if (cnt_q == CNTW'(ROWS + 1)) begin
      step_rd_row = '0;
    end else begin
      step_rd_row = cnt_m1[RW-1:0];
    end
  end

  assign rd_row = cmd_i.rd_cell ? row_idx : step_rd_row;

  always_comb begin
    rmw_row = rd_data_q;
    if (in_grid) begin
      rmw_row[col_idx] = (func_q == FUNC_TOGGLE) ? ~rd_data_q[col_idx] : value_q;
    end
  end

  for (genvar c = 0; c < COLS; c++) begin : g_life
    localparam int L = (c + COLS - 1) % COLS;
    localparam int R = (c + 1) % COLS;
    logic [3:0] n;
    assign n = 4'(win0_q[L]) + 4'(win0_q[c]) + 4'(win0_q[R]) +
               4'(win1_q[L]) + 4'(win1_q[R]) +
               4'(rd_data_q[L]) + 4'(rd_data_q[c]) + 4'(rd_data_q[R]);
    assign life_row[c] = (n == 4'd3) | (win1_q[c] & (n == 4'd2));
  end

  always_comb begin
    wr_en   = cmd_i.wr_zero | cmd_i.wr_cell | cmd_i.wr_life;
    wr_bank = cmd_i.wr_life ? ~sel_q : sel_q;
    if (cmd_i.wr_cell) begin
      wr_row  = row_idx;
      wr_data = rmw_row;
    end else if (cmd_i.wr_life) begin
      wr_row  = cnt_m3[RW-1:0];
      wr_data = life_row;
    end else begin
      wr_row  = cnt_q[RW-1:0];
      wr_data = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_bank][wr_row] <= wr_data;
    end
    if (cmd_i.rd_cell || cmd_i.rd_step) begin
      rd_data_q <= mem_q[sel_q][rd_row];
    end
    if (cmd_i.shift) begin
      win0_q <= win1_q;
      win1_q <= rd_data_q;
    end
    if (cmd_i.capture) begin
      func_q   <= func_i;
      row_q    <= row_i;
      column_q <= column_i;
      value_q  <= value_i;
    end
    if (cmd_i.load_res) begin
      cell_bit_q    <= res_cell;
      took_effect_q <= res_took;
    end
  end

  always_comb begin
    res_cell = 1'b0;
    case (func_q)
      FUNC_WRITE:  res_took = in_grid;
      FUNC_TOGGLE: res_took = in_grid & ~running_q;
      FUNC_CLEAR:  res_took = ~running_q;
      FUNC_STEP:   res_took = running_q;
      FUNC_READ: begin
        res_took = in_grid;
        res_cell = in_grid ? rd_data_q[col_idx] : 1'b0;
      end
      default:     res_took = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= 1'b0;
      running_q   <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        running_q <= cfg_wdata_i;
      end
      if (cmd_i.flip) begin
        sel_q <= ~sel_q;
      end
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + CNTW'(1);
      end
      if (cmd_i.load_res) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.func       = func_q;
  assign status_o.in_grid    = in_grid;
  assign status_o.running    = running_q;
  assign status_o.clear_last = (cnt_q == CNTW'(ROWS - 1));
  assign status_o.step_last  = (cnt_q == CNTW'(ROWS + 2));
  assign status_o.step_ge1   = (cnt_q >= CNTW'(1));
  assign status_o.step_ge3   = (cnt_q >= CNTW'(3));
  assign status_o.out_busy   = out_valid_q & ~out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign cell_bit_o    = cell_bit_q;
  assign took_effect_o = took_effect_q;

endmodule

// ===== design/tlg_controller.sv =====
// ----------------------------------------------------------------------------
// tlg_controller
// sequencer for reset clearing, cell access, grid clear and generation step
// ----------------------------------------------------------------------------
module tlg_controller import tlg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  tlg_status_t status_i,
  output tlg_cmd_t    cmd_o
);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_CELL   = 3'd3;
  localparam logic [2:0] ST_CLEAR  = 3'd4;
  localparam logic [2:0] ST_STEP   = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_INIT: begin
        cmd_o.wr_zero = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (status_i.clear_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d       = ST_FINISH;
        cmd_o.cnt_clr = 1'b1;
        case (status_i.func)
          FUNC_WRITE, FUNC_READ: begin
            if (status_i.in_grid) begin
              cmd_o.rd_cell = 1'b1;
              state_d       = ST_CELL;
            end
          end
          FUNC_TOGGLE: begin
            if (status_i.in_grid && !status_i.running) begin
              cmd_o.rd_cell = 1'b1;
              state_d       = ST_CELL;
            end
          end
          FUNC_CLEAR: begin
            if (!status_i.running) begin
              state_d = ST_CLEAR;
            end
          end
          FUNC_STEP: begin
            if (status_i.running) begin
              state_d = ST_STEP;
            end
          end
          default: state_d = ST_FINISH;
        endcase
      end
      ST_CELL: begin
        cmd_o.wr_cell = (status_i.func == FUNC_WRITE) || (status_i.func == FUNC_TOGGLE);
        state_d       = ST_FINISH;
      end
      ST_CLEAR: begin
        cmd_o.wr_zero = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_STEP: begin
        cmd_o.rd_step = ~status_i.step_last;
        cmd_o.shift   = status_i.step_ge1;
        cmd_o.wr_life = status_i.step_ge3;
        cmd_o.cnt_inc = 1'b1;
        if (status_i.step_last) begin
          cmd_o.flip = 1'b1;
          state_d    = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!status_i.out_busy) begin
          cmd_o.load_res = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/toroidal_life_grid_engine.sv =====
// ----------------------------------------------------------------------------
// toroidal_life_grid_engine
// life grid on a torus with cell access, clear and generation step
// ----------------------------------------------------------------------------
// input channel: in_valid_i/in_ready_o carry one word (func, row, column,
// value); output channel: out_valid_o/out_ready_i carry one word per input
// (cell_bit, took_effect). running is set through cfg_we_i/cfg_wdata_i.
// the grid sits in a memory of ROWS rows, each COLS cells wide, in two banks;
// a generation step streams rows of the live bank through a three-row window
// and writes the new rows into the other bank, then swaps banks.
// one word at a time. write, toggle, read: decide, then a cell read and,
// for write and toggle, a write-back. clear: one row cleared per cycle
// through the write port. step: rows stream through the single row read
// port (ROWS + 2 reads). ignored operations go from decide to the result.
// after reset the live bank is cleared row by row while in_ready_o is low.
// the result register lets the next word be accepted while a result waits;
// with the receiver stalled that next word holds in its last cycle until the
// waiting result is taken.
// ----------------------------------------------------------------------------
module toroidal_life_grid_engine import tlg_pkg::*; #(
  parameter int ROWS = DEF_ROWS,
  parameter int COLS = DEF_COLS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [ROW_W-1:0]  row_i,
  input  logic [COL_W-1:0]  column_i,
  input  logic              value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              cell_bit_o,
  output logic              took_effect_o
);

  tlg_cmd_t    cmd;
  tlg_status_t status;

  tlg_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tlg_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .func_i        (func_i),
    .row_i         (row_i),
    .column_i      (column_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .cell_bit_o    (cell_bit_o),
    .took_effect_o (took_effect_o)
  );

endmodule

// ===== tb/toroidal_life_grid_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toroidal_life_grid_engine_tb
// self-checking bench for the life grid engine: a built-in grid model
// predicts every result word from the accepted input words, covering
// directed edge and wrap-around cases, both modes of the running flag,
// random pattern building and generation steps, random handshake gaps, a
// long output stall and a full drain of the engine
// ----------------------------------------------------------------------------
module toroidal_life_grid_engine_tb;
  import tlg_pkg::*;

  localparam int ROWS         = DEF_ROWS;
  localparam int COLS         = DEF_COLS;
  localparam int LIMIT_CYCLES = 200000;
  localparam int SETTLE       = 8;
  localparam int TAIL         = 80;
  localparam int CALM_LO      = 40;
  localparam int CALM_HI      = 75;
  localparam int HOLD_AT      = 100;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_SHOWN    = 10;

  typedef struct packed {
    logic alive;
    logic took;
  } grid_result_t;

  class life_grid_model;
    localparam int KEEP_LO = 2;
    localparam int KEEP_HI = 3;
    localparam int BIRTH   = 3;

    bit           cells [ROWS][COLS];
    bit           running;
    grid_result_t expected_q[$];
    int           mismatches;
    int           checked;

    function void advance();
      bit nxt [ROWS][COLS];
      int n;
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < COLS; c++) begin
          n = 0;
          for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
              if (dr != 0 || dc != 0)
                n += cells[(r + dr + ROWS) % ROWS][(c + dc + COLS) % COLS];
            end
          end
          if (cells[r][c])
            nxt[r][c] = (n == KEEP_LO || n == KEEP_HI);
          else
            nxt[r][c] = (n == BIRTH);
        end
      end
      cells = nxt;
    endfunction

    function void note_word(logic [FUNC_W-1:0] f, logic [ROW_W-1:0] r,
                            logic [COL_W-1:0] c, logic v);
      grid_result_t res;
      bit in_grid;
      in_grid = (r < ROWS) && (c < COLS);
      res = '0;
      case (f)
        FUNC_WRITE: begin
          if (in_grid) begin
            cells[r][c] = v;
            res.took = 1'b1;
          end
        end
        FUNC_TOGGLE: begin
          if (in_grid && !running) begin
            cells[r][c] = !cells[r][c];
            res.took = 1'b1;
          end
        end
        FUNC_CLEAR: begin
          if (!running) begin
            cells = '{default: '0};
            res.took = 1'b1;
          end
        end
        FUNC_STEP: begin
          if (running) begin
            advance();
            res.took = 1'b1;
          end
        end
        FUNC_READ: begin
          if (in_grid) begin
            res.alive = cells[r][c];
            res.took = 1'b1;
          end
        end
        default: ;
      endcase
      expected_q.push_back(res);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= MAX_SHOWN)
        $display("%s", msg);
    endfunction

    function void check_word(logic alive, logic took);
      grid_result_t want;
      if (expected_q.size() == 0) begin
        flag($sformatf("result word with none pending: cell_bit %0b took_effect %0b",
                       alive, took));
        return;
      end
      want = expected_q.pop_front();
      if (alive !== want.alive)
        flag($sformatf("word %0d cell_bit: expected %0b, got %0b", checked,
                       want.alive, alive));
      if (took !== want.took)
        flag($sformatf("word %0d took_effect: expected %0b, got %0b", checked,
                       want.took, took));
      checked++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic              cfg_wdata_i = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [FUNC_W-1:0] func_i = '0;
  logic [ROW_W-1:0]  row_i = '0;
  logic [COL_W-1:0]  column_i = '0;
  logic              value_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              cell_bit_o;
  logic              took_effect_o;

  life_grid_model grid = new();
  int             words_sent;
  int             results_seen;
  int             cycles;

  toroidal_life_grid_engine dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .row_i        (row_i),
    .column_i     (column_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cell_bit_o   (cell_bit_o),
    .took_effect_o(took_effect_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random stalls, one calm stretch and one long hold-off
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        grid.check_word(cell_bit_o, took_effect_o);
        results_seen++;
      end
      if (!held && results_seen == HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (results_seen >= CALM_LO && results_seen < CALM_HI) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= 25);
      end
    end
  end

  function automatic int pick_gap();
    if (words_sent >= CALM_LO && words_sent < CALM_HI)
      return 0;
    if ($urandom_range(0, 99) < 25)
      return $urandom_range(1, 6);
    return 0;
  endfunction

  task automatic send_word(input logic [FUNC_W-1:0] f, input int r, input int c,
                           input logic v);
    int gap;
    func_i     <= f;
    row_i      <= ROW_W'(r);
    column_i   <= COL_W'(c);
    value_i    <= v;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    grid.note_word(f, ROW_W'(r), COL_W'(c), v);
    words_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (grid.pending() != 0) @(posedge clk_i);
  endtask

  task automatic set_running(input bit v);
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    grid.running = v;
  endtask

  // pattern building while stopped, stepping and probing while running;
  // addresses cluster in a small window that often straddles the wrap
  task automatic random_phase(input int count, input bit pause_mid);
    int base_r;
    int base_c;
    int pick;
    int r;
    int c;
    logic [FUNC_W-1:0] f;
    base_r = $urandom_range(0, 1) ? ROWS - 4 : $urandom_range(0, ROWS - 1);
    base_c = $urandom_range(0, 1) ? COLS - 4 : $urandom_range(0, COLS - 1);
    for (int i = 0; i < count; i++) begin
      if (pause_mid && i == count / 2)
        wait_drained();
      pick = $urandom_range(0, 99);
      if (grid.running) begin
        if (pick < 35)      f = FUNC_STEP;
        else if (pick < 75) f = FUNC_READ;
        else if (pick < 90) f = FUNC_WRITE;
        else if (pick < 93) f = FUNC_TOGGLE;
        else if (pick < 96) f = FUNC_CLEAR;
        else                f = FUNC_W'(FUNC_READ + $urandom_range(1, 3));
      end else begin
        if (pick < 40)      f = FUNC_WRITE;
        else if (pick < 65) f = FUNC_TOGGLE;
        else if (pick < 90) f = FUNC_READ;
        else if (pick < 93) f = FUNC_CLEAR;
        else if (pick < 96) f = FUNC_STEP;
        else                f = FUNC_W'(FUNC_READ + $urandom_range(1, 3));
      end
      if ($urandom_range(0, 99) < 85) begin
        r = (base_r + $urandom_range(0, 7)) % ROWS;
        c = (base_c + $urandom_range(0, 7)) % COLS;
      end else begin
        r = $urandom_range(0, (1 << ROW_W) - 1);
        c = $urandom_range(0, (1 << COL_W) - 1);
      end
      send_word(f, r, c, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    set_running(1'b0);

    // stopped: cell access at the corners, toggles, gated step, spare codes
    send_word(FUNC_READ, 0, 0, 1'b0);
    send_word(FUNC_WRITE, 0, 0, 1'b1);
    send_word(FUNC_WRITE, ROWS - 1, COLS - 1, 1'b1);
    send_word(FUNC_READ, ROWS - 1, COLS - 1, 1'b0);
    send_word(FUNC_TOGGLE, 0, COLS - 1, 1'b0);
    send_word(FUNC_TOGGLE, 0, COLS - 1, 1'b1);
    send_word(FUNC_TOGGLE, ROWS - 1, 0, 1'b0);
    send_word(FUNC_STEP, 0, 0, 1'b0);
    for (int f = FUNC_READ + 1; f < (1 << FUNC_W); f++)
      send_word(FUNC_W'(f), ROWS - 1, COLS - 1, 1'b1);
    send_word(FUNC_CLEAR, ROWS - 1, COLS - 1, 1'b1);
    send_word(FUNC_READ, 0, 0, 1'b0);
    // blinker straddling the column wrap
    send_word(FUNC_WRITE, 0, COLS - 1, 1'b1);
    send_word(FUNC_WRITE, 0, 0, 1'b1);
    send_word(FUNC_WRITE, 0, 1, 1'b1);
    send_word(FUNC_WRITE, 5, 5, 1'b0);

    // running: gated toggle and clear, steps across the row wrap
    set_running(1'b1);
    send_word(FUNC_TOGGLE, 0, 0, 1'b0);
    send_word(FUNC_CLEAR, 0, 0, 1'b0);
    send_word(FUNC_STEP, 0, 0, 1'b0);
    send_word(FUNC_READ, ROWS - 1, 0, 1'b0);
    send_word(FUNC_READ, 0, COLS - 1, 1'b0);
    send_word(FUNC_STEP, 0, 0, 1'b0);
    send_word(FUNC_READ, 0, COLS - 1, 1'b0);
    send_word(FUNC_READ, ROWS - 1, 0, 1'b0);

    for (int p = 0; p < 6; p++) begin
      set_running(1'(p % 2));
      random_phase(20, p == 2);
    end

    wait_drained();
    repeat (TAIL) @(posedge clk_i);
    if (grid.mismatches == 0 && grid.pending() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
